// ===== sv/ial_pkg.sv =====
// ----------------------------------------------------------------------------
// ial_pkg
// Shared types, sizes and codes of the indexed array list unit.
// ----------------------------------------------------------------------------
package ial_pkg;

    localparam int DEPTH      = 64;
    localparam int ITEM_WIDTH = 32;

    // fixed field widths
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    // internal widths
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // opcodes
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
    localparam logic [OP_W-1:0] OP_REPLACE = 3'd2;
    localparam logic [OP_W-1:0] OP_GET     = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND    = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    // cell source select
    typedef logic [1:0] cell_sel_t;
    localparam cell_sel_t SEL_HOLD  = 2'd0;
    localparam cell_sel_t SEL_LOAD  = 2'd1;
    localparam cell_sel_t SEL_LOWER = 2'd2;
    localparam cell_sel_t SEL_UPPER = 2'd3;

    // chain commands
    localparam logic [2:0] CMD_HOLD   = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_WRITE  = 3'd3;
    localparam logic [2:0] CMD_ROTATE = 3'd4;

    typedef logic [ITEM_WIDTH-1:0] item_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] count;
        item_t            data;
    } chain_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0]           opcode;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] read_value;
        logic                      found;
        logic [POS_W-1:0]          found_position;
        logic [LEN_W-1:0]          list_length;
        logic                      is_empty;
        logic                      is_full;
    } rsp_t;

endpackage

// ===== sv/ial_cell.sv =====
// ----------------------------------------------------------------------------
// ial_cell
// One list slot: holds an item, or takes it from a neighbor or the write bus.
// ----------------------------------------------------------------------------
module ial_cell (
    input  logic              clk,
    input  ial_pkg::cell_sel_t sel,
    input  ial_pkg::item_t    wr_data,
    input  ial_pkg::item_t    lower_data,
    input  ial_pkg::item_t    upper_data,
    output ial_pkg::item_t    data
);
    import ial_pkg::*;

    item_t data_reg;
    item_t data_next;

    always_comb
    begin
        case (sel)
            SEL_HOLD:  data_next = data_reg;
            SEL_LOAD:  data_next = wr_data;
            SEL_LOWER: data_next = lower_data;
            SEL_UPPER: data_next = upper_data;
            default:   data_next = data_reg;
        endcase
    end

    // slot contents are undefined until written
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== sv/ial_chain.sv =====
// ----------------------------------------------------------------------------
// ial_chain
// Ring of list cells; decodes one command into a select for every cell.
// ----------------------------------------------------------------------------
module ial_chain (
    input  logic                clk,
    input  ial_pkg::chain_cmd_t cmd,
    output ial_pkg::item_t      head
);
    import ial_pkg::*;

    item_t     cell_data [DEPTH];
    cell_sel_t cell_sel  [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic at_idx;
        logic above_idx;
        logic in_used;
        logic below_last;

        assign at_idx     = (IDX_W'(i) == cmd.idx);
        assign above_idx  = (IDX_W'(i) > cmd.idx);
        // slot lies at or below count, the top slot after an insert
        assign in_used    = (CNT_W'(i) <= cmd.count);
        // slot has a used slot above it
        assign below_last = (CNT_W'(i + 1) < cmd.count);

        always_comb
        begin
            case (cmd.kind)
                CMD_INSERT:
                begin
                    if (at_idx)
                        cell_sel[i] = SEL_LOAD;
                    else if (above_idx && in_used)
                        cell_sel[i] = SEL_LOWER;
                    else
                        cell_sel[i] = SEL_HOLD;
                end
                CMD_REMOVE:
                    cell_sel[i] = ((at_idx || above_idx) && below_last) ? SEL_UPPER : SEL_HOLD;
                CMD_WRITE:
                    cell_sel[i] = at_idx ? SEL_LOAD : SEL_HOLD;
                CMD_ROTATE:
                    cell_sel[i] = SEL_UPPER;
                default:
                    cell_sel[i] = SEL_HOLD;
            endcase
        end

        ial_cell u_cell (
            .clk        (clk),
            .sel        (cell_sel[i]),
            .wr_data    (cmd.data),
            .lower_data (cell_data[(i + DEPTH - 1) % DEPTH]),
            .upper_data (cell_data[(i + 1) % DEPTH]),
            .data       (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule

// ===== sv/indexed_array_list_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_array_list_unit
// Ordered list of up to DEPTH items kept in a ring of cells, by 1-based index.
// ----------------------------------------------------------------------------
// insert, remove, replace, a rejected request or an unknown opcode: the chain
// is updated as the request is accepted (a rejected one leaves it unchanged),
// and the response passes through the result and then the output register
// get and find rotate the whole ring past cell 0 once before the result is set;
// one request is in work at a time: a new request is taken only once the last
// result has left the result register, and never during a scan
// reset clears the item count and all control; cell contents stay undefined
// ----------------------------------------------------------------------------
module indexed_array_list_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ial_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ial_pkg::rsp_t rsp
);
    import ial_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic             state_reg,     state_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic [IDX_W-1:0] step_reg,      step_next;
    logic             res_valid_reg, res_valid_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             res_reg,       res_next;
    rsp_t             rsp_reg,       rsp_next;
    logic             scan_find_reg, scan_find_next;
    logic [IDX_W-1:0] scan_idx_reg,  scan_idx_next;
    item_t            scan_val_reg,  scan_val_next;
    logic             hit_reg,       hit_next;
    logic [POS_W-1:0] hit_pos_reg,   hit_pos_next;
    item_t            rd_reg,        rd_next;

    chain_cmd_t cmd;
    item_t      head;
    item_t      req_item;
    logic [CMP_W-1:0] pos_w;
    logic [CMP_W-1:0] cnt_w;
    logic       pos_in_list;
    logic       pos_for_insert;
    logic       list_full;
    logic       accept;
    logic       res_set;
    logic       res_move;
    logic       last_step;

    function automatic rsp_t make_rsp(
        input logic [STATUS_W-1:0] status,
        input item_t               rd,
        input logic                fnd,
        input logic [POS_W-1:0]    fpos,
        input logic [CNT_W-1:0]    cnt
    );
        rsp_t r;
        r.status         = status;
        r.read_value     = VALUE_W'(rd);
        r.found          = fnd;
        r.found_position = fpos;
        r.list_length    = LEN_W'(cnt);
        r.is_empty       = (cnt == '0);
        r.is_full        = (cnt == CNT_W'(DEPTH));
        return r;
    endfunction

    assign req_item       = ITEM_WIDTH'($unsigned(req.value));
    assign pos_w          = CMP_W'(req.position);
    assign cnt_w          = CMP_W'(count_reg);
    assign pos_in_list    = (pos_w != '0) && (pos_w <= cnt_w);
    assign pos_for_insert = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1));
    assign list_full      = (count_reg == CNT_W'(DEPTH));
    assign last_step      = (step_reg == IDX_W'(DEPTH - 1));

    assign req_ready = (state_reg == ST_IDLE) && !res_valid_reg;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        scan_find_next = scan_find_reg;
        scan_idx_next  = scan_idx_reg;
        scan_val_next  = scan_val_reg;
        hit_next       = hit_reg;
        hit_pos_next   = hit_pos_reg;
        rd_next        = rd_reg;
        res_set        = 1'b0;
        res_next       = res_reg;
        cmd.kind       = CMD_HOLD;
        cmd.idx        = IDX_W'(pos_w - CMP_W'(1));
        cmd.count      = count_reg;
        cmd.data       = req_item;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_set       = 1'b1;
                    res_next      = make_rsp(STATUS_OK, '0, 1'b0, '0, count_reg);
                    scan_idx_next = IDX_W'(pos_w - CMP_W'(1));
                    scan_val_next = req_item;
                    hit_next      = 1'b0;
                    hit_pos_next  = '0;
                    rd_next       = '0;
                    step_next     = '0;
                    case (req.opcode)
                        OP_INSERT:
                        begin
                            if (!pos_for_insert)
                                res_next = make_rsp(STATUS_BAD_INDEX, '0, 1'b0, '0, count_reg);
                            else if (list_full)
                                res_next = make_rsp(STATUS_FULL, '0, 1'b0, '0, count_reg);
                            else
                            begin
                                cmd.kind   = CMD_INSERT;
                                count_next = count_reg + CNT_W'(1);
                                res_next   = make_rsp(STATUS_OK, '0, 1'b0, '0, count_next);
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!pos_in_list)
                                res_next = make_rsp(STATUS_BAD_INDEX, '0, 1'b0, '0, count_reg);
                            else
                            begin
                                cmd.kind   = CMD_REMOVE;
                                count_next = count_reg - CNT_W'(1);
                                res_next   = make_rsp(STATUS_OK, '0, 1'b0, '0, count_next);
                            end
                        end
                        OP_REPLACE:
                        begin
                            if (!pos_in_list)
                                res_next = make_rsp(STATUS_BAD_INDEX, '0, 1'b0, '0, count_reg);
                            else
                                cmd.kind = CMD_WRITE;
                        end
                        OP_GET:
                        begin
                            if (!pos_in_list)
                                res_next = make_rsp(STATUS_BAD_INDEX, '0, 1'b0, '0, count_reg);
                            else
                            begin
                                res_set        = 1'b0;
                                scan_find_next = 1'b0;
                                state_next     = ST_SCAN;
                            end
                        end
                        OP_FIND:
                        begin
                            res_set        = 1'b0;
                            scan_find_next = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        default:
                        begin
                            res_set = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // cell 0 holds list entry step_reg before this rotation
                cmd.kind = CMD_ROTATE;
                if (scan_find_reg)
                begin
                    if (!hit_reg && (CNT_W'(step_reg) < count_reg) && (head == scan_val_reg))
                    begin
                        hit_next     = 1'b1;
                        hit_pos_next = POS_W'(CNT_W'(step_reg) + CNT_W'(1));
                    end
                end
                else if (step_reg == scan_idx_reg)
                begin
                    rd_next = head;
                end
                if (last_step)
                begin
                    step_next  = '0;
                    state_next = ST_IDLE;
                    res_set    = 1'b1;
                    res_next   = make_rsp(STATUS_OK, rd_next, hit_next, hit_pos_next,
                                          count_reg);
                end
                else
                    step_next = step_reg + IDX_W'(1);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // response moves to the output register when that slot is free or its response is taken
    assign res_move       = res_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign res_valid_next = res_set || (res_valid_reg && !res_move);
    assign rsp_valid_next = res_move || (rsp_valid_reg && !rsp_ready);
    assign rsp_next       = res_move ? res_reg : rsp_reg;

    ial_chain u_chain (
        .clk  (clk),
        .cmd  (cmd),
        .head (head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
        scan_find_reg <= scan_find_next;
        scan_idx_reg  <= scan_idx_next;
        scan_val_reg  <= scan_val_next;
        hit_reg       <= hit_next;
        hit_pos_reg   <= hit_pos_next;
        rd_reg        <= rd_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("item count above depth");

    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && last_step) |=> (state_reg == ST_IDLE && res_valid_reg))
        else $error("scan did not finish with a response");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (!req_ready && $stable(count_reg)))
        else $error("request taken or count changed during scan");

endmodule
